// ===== hw/rtl/alps_pkg.sv =====
// ----------------------------------------------------------------------------
// alps_pkg
// Shared types and constants of the addressable LED PWM serializer.
// ----------------------------------------------------------------------------
package alps_pkg;

  localparam int MAX_LEDS_DEF    = 256;
  localparam int RESET_SLOTS_DEF = 50;

  localparam logic [15:0] PERIOD_RESET = 16'd89;
  localparam logic [4:0]  BIT_HI       = 5'd23;

  // x / 3 == (x * RECIP3) >> RECIP_SHIFT, exact for x < 2**19
  localparam logic [17:0] RECIP3      = 18'd174763;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [2:0] ACT_SET_LED   = 3'd0;
  localparam logic [2:0] ACT_SET_ALL   = 3'd1;
  localparam logic [2:0] ACT_CLEAR_ALL = 3'd2;
  localparam logic [2:0] ACT_START     = 3'd3;
  localparam logic [2:0] ACT_TICK      = 3'd4;

  localparam logic REG_CHAIN_LEN  = 1'b0;
  localparam logic REG_PWM_PERIOD = 1'b1;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic [15:0] compare_value;
    logic        slot_valid;
    logic        last_slot;
    logic        busy_res;
    logic        rejected;
  } out_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic sweep_full;
    logic fill_load;
    logic calc;
  } cmd_t;

  typedef struct packed {
    logic need_fill;
    logic need_calc;
    logic sweep_end;
    logic out_free;
  } sts_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_FILL  = 4'b0100,
    ST_CALC  = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/addressable_led_pwm_serializer.sv =====
// ----------------------------------------------------------------------------
// addressable_led_pwm_serializer
// Colour store and PWM compare sequencer for a chain of addressable LEDs.
//
// Input words carry an action (set LED, set all, clear all, start frame,
// slot tick) with an index and a colour; every input word gives exactly one
// output word. Both channels use valid/stall. cfg_write loads the chain length
// (index 0) or pwm_period (index 1); the user is to write it only while the
// block is idle, which the block itself does not enforce. For set LED, start,
// unused codes and ticks outside the bit phase the output word follows in the
// cycle after acceptance; a tick that sends a colour bit passes the store
// read, then the divide-by-three multiply; set all and clear all first sweep
// the store one entry per cycle over the effective LED count. One word is in
// flight at a time, and a new word is taken only while the output register
// is empty or drains. After reset the store is cleared one entry per cycle;
// in_stall stays high until all MAX_LEDS entries are cleared. A stalled
// receiver holds the output word and, through it, the input channel.
// ----------------------------------------------------------------------------
module addressable_led_pwm_serializer #(
  parameter int MAX_LEDS    = alps_pkg::MAX_LEDS_DEF,
  parameter int RESET_SLOTS = alps_pkg::RESET_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  alps_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output alps_pkg::out_t out_data,
  input  logic           cfg_write,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data
);

  alps_pkg::cmd_t cmd;
  alps_pkg::sts_t sts;

  alps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  alps_dp #(
    .MAX_LEDS    (MAX_LEDS),
    .RESET_SLOTS (RESET_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== hw/rtl/alps_ram.sv =====
// ----------------------------------------------------------------------------
// alps_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module alps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/alps_ctrl.sv =====
// ----------------------------------------------------------------------------
// alps_ctrl
// Sequencer: reset clearing pass, store sweeps and bit slot compare.
// ----------------------------------------------------------------------------
module alps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  alps_pkg::sts_t sts,
  output alps_pkg::cmd_t cmd
);

  alps_pkg::state_t state;
  alps_pkg::state_t state_next;
  logic             ready;

  assign ready    = (state == alps_pkg::ST_IDLE) && sts.out_free;
  assign in_stall = !ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      alps_pkg::ST_CLEAR: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_full = 1'b1;
        if (sts.sweep_end) begin
          state_next = alps_pkg::ST_IDLE;
        end
      end
      alps_pkg::ST_IDLE: begin
        if (in_valid && ready) begin
          cmd.accept = 1'b1;
          if (sts.need_fill) begin
            state_next = alps_pkg::ST_FILL;
          end else if (sts.need_calc) begin
            state_next = alps_pkg::ST_CALC;
          end
        end
      end
      alps_pkg::ST_FILL: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_end) begin
          cmd.fill_load = 1'b1;
          state_next    = alps_pkg::ST_IDLE;
        end
      end
      alps_pkg::ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = alps_pkg::ST_IDLE;
      end
      default: begin
        state_next = alps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alps_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/alps_dp.sv =====
// ----------------------------------------------------------------------------
// alps_dp
// Datapath: registers, colour store, frame position and compare arithmetic.
// ----------------------------------------------------------------------------
module alps_dp #(
  parameter int MAX_LEDS    = alps_pkg::MAX_LEDS_DEF,
  parameter int RESET_SLOTS = alps_pkg::RESET_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  alps_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output alps_pkg::out_t out_data,
  input  logic           cfg_write,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data,
  input  alps_pkg::cmd_t cmd,
  output alps_pkg::sts_t sts
);

  localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W = $clog2(MAX_LEDS + 1);
  localparam int WW    = (CNT_W > 9) ? CNT_W : 9;
  localparam int TW    = (RESET_SLOTS > 1) ? $clog2(RESET_SLOTS) : 1;

  logic [8:0]       chain_len;
  logic [15:0]      pwm_period;
  logic [CNT_W-1:0] led_position;
  logic [4:0]       bit_position;
  logic [TW-1:0]    tail_position;
  logic             sending;
  logic [CNT_W-1:0] sweep_addr;
  logic [23:0]      fill_data;

  logic [WW-1:0]    count_w;
  logic [WW-1:0]    idx_w;
  logic [WW-1:0]    pos_w;
  logic [WW-1:0]    sweep_w;
  logic [WW-1:0]    sweep_limit;
  logic             idx_ok;
  logic             pos_ok;
  logic             sweep_end;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [23:0]      ram_wdata;
  logic [23:0]      ram_rdata;

  logic [16:0]      period1;
  logic [17:0]      dividend;
  logic [35:0]      product;
  logic             data_bit;

  logic             out_load;
  alps_pkg::out_t   out_next;

  assign count_w = (WW'(chain_len) > WW'(MAX_LEDS)) ? WW'(MAX_LEDS) : WW'(chain_len);
  assign idx_w   = WW'(in_data.led_index);
  assign pos_w   = WW'(led_position);
  assign sweep_w = WW'(sweep_addr);
  assign idx_ok  = idx_w < count_w;
  assign pos_ok  = pos_w < count_w;

  assign sweep_limit = cmd.sweep_full ? WW'(MAX_LEDS) : count_w;
  assign sweep_end   = sweep_w >= sweep_limit;

  assign sts.need_fill = (in_data.action == alps_pkg::ACT_SET_ALL) ||
                         (in_data.action == alps_pkg::ACT_CLEAR_ALL);
  assign sts.need_calc = (in_data.action == alps_pkg::ACT_TICK) && sending && pos_ok;
  assign sts.sweep_end = sweep_end;
  assign sts.out_free  = !out_valid || !out_stall;

  assign ram_we    = (cmd.sweep && !sweep_end) ||
                     (cmd.accept && (in_data.action == alps_pkg::ACT_SET_LED) && idx_ok);
  assign ram_waddr = cmd.sweep ? sweep_w[AW-1:0] : idx_w[AW-1:0];
  assign ram_wdata = cmd.sweep ? fill_data
                               : {in_data.blue, in_data.green, in_data.red};

  alps_ram #(
    .WIDTH (24),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (pos_w[AW-1:0]),
    .rd_data (ram_rdata)
  );

  assign period1  = {1'b0, pwm_period} + 17'd1;
  assign data_bit = ram_rdata[alps_pkg::BIT_HI - bit_position];
  assign dividend = data_bit ? {period1, 1'b0} : {1'b0, period1};
  assign product  = dividend * alps_pkg::RECIP3;

  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (cmd.accept) begin
      case (in_data.action)
        alps_pkg::ACT_SET_LED: begin
          out_load          = 1'b1;
          out_next.busy_res = sending;
          out_next.rejected = !idx_ok;
        end
        alps_pkg::ACT_SET_ALL, alps_pkg::ACT_CLEAR_ALL: begin
          out_load = 1'b0;
        end
        alps_pkg::ACT_START: begin
          out_load          = 1'b1;
          out_next.busy_res = 1'b1;
          out_next.rejected = sending;
        end
        alps_pkg::ACT_TICK: begin
          if (!sending) begin
            out_load = 1'b1;
          end else if (!pos_ok) begin
            out_load            = 1'b1;
            out_next.slot_valid = 1'b1;
            out_next.last_slot  = (tail_position == TW'(RESET_SLOTS - 1));
            out_next.busy_res   = (tail_position != TW'(RESET_SLOTS - 1));
          end
        end
        default: begin
          out_load          = 1'b1;
          out_next.busy_res = sending;
        end
      endcase
    end else if (cmd.fill_load) begin
      out_load          = 1'b1;
      out_next.busy_res = sending;
    end else if (cmd.calc) begin
      out_load               = 1'b1;
      out_next.compare_value = product[alps_pkg::RECIP_SHIFT +: 16];
      out_next.slot_valid    = 1'b1;
      out_next.busy_res      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_len     <= '0;
      pwm_period    <= alps_pkg::PERIOD_RESET;
      led_position  <= '0;
      bit_position  <= '0;
      tail_position <= '0;
      sending       <= 1'b0;
      sweep_addr    <= '0;
      fill_data     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          alps_pkg::REG_CHAIN_LEN:  chain_len  <= cfg_data[8:0];
          alps_pkg::REG_PWM_PERIOD: pwm_period <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.sweep && !sweep_end) begin
        sweep_addr <= sweep_addr + CNT_W'(1);
      end

      if (cmd.accept) begin
        case (in_data.action)
          alps_pkg::ACT_SET_ALL: begin
            fill_data  <= {in_data.blue, in_data.green, in_data.red};
            sweep_addr <= '0;
          end
          alps_pkg::ACT_CLEAR_ALL: begin
            fill_data  <= '0;
            sweep_addr <= '0;
          end
          alps_pkg::ACT_START: begin
            if (!sending) begin
              sending       <= 1'b1;
              led_position  <= '0;
              bit_position  <= '0;
              tail_position <= '0;
            end
          end
          alps_pkg::ACT_TICK: begin
            if (sending && !pos_ok) begin
              if (tail_position == TW'(RESET_SLOTS - 1)) begin
                sending       <= 1'b0;
                led_position  <= '0;
                bit_position  <= '0;
                tail_position <= '0;
              end else begin
                tail_position <= tail_position + TW'(1);
              end
            end
          end
          default: ;
        endcase
      end

      if (cmd.calc) begin
        if (bit_position == alps_pkg::BIT_HI) begin
          bit_position <= '0;
          led_position <= led_position + CNT_W'(1);
        end else begin
          bit_position <= bit_position + 5'd1;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

endmodule

// ===== verif/tb_addressable_led_pwm_serializer.sv =====
// ----------------------------------------------------------------------------
// tb_addressable_led_pwm_serializer
// Self-checking bench for the addressable LED PWM serializer.
//
// A queue of words feeds a valid/stall driver. Each accepted word runs through
// a local predictor that holds the colour store, the frame position and the
// register copies, and its expected output word is queued. A monitor takes the
// output words under random stall and compares every field in order. A short
// directed set opens the run. Register settings then change between drained
// phases, from zero LEDs up to a clamped count and over the whole period
// range. Each phase queues frames (colour writes, start, bit and tail slot
// ticks, strays mixed in) up to PHASE_WORDS words, so long chains stop mid-frame.
// ----------------------------------------------------------------------------
module tb_addressable_led_pwm_serializer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
  localparam int COLOUR_BITS  = 24;
  localparam int PHASE_WORDS  = 166;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_WAIT   = 300;
  localparam int QUIET_LIMIT  = 5000;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  alps_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  alps_pkg::out_t out_data;
  logic           cfg_write = 1'b0;
  logic           cfg_index = 1'b0;
  logic [15:0]    cfg_data  = '0;

  alps_pkg::in_t  pending [$];
  alps_pkg::out_t slots_due [$];

  logic [23:0] colour_mem [alps_pkg::MAX_LEDS_DEF] = '{default: '0};
  logic [8:0]  cfg_leds   = '0;
  logic [15:0] cfg_period = alps_pkg::PERIOD_RESET;
  int          cur_led    = 0;
  int          cur_bit    = 0;
  int          tail_cnt   = 0;
  bit          frame_on   = 1'b0;

  bit send_idle_on = 1'b0;
  bit recv_idle_on = 1'b0;
  int send_gap     = 0;
  int recv_hold    = 0;
  int quiet_cycles = 0;
  int words_in     = 0;
  int results_seen = 0;
  int frames_done  = 0;
  int rejects_seen = 0;
  int settings     = 0;
  int fail_count   = 0;

  addressable_led_pwm_serializer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_leds();
    return (int'(cfg_leds) > alps_pkg::MAX_LEDS_DEF) ? alps_pkg::MAX_LEDS_DEF
                                                     : int'(cfg_leds);
  endfunction

  function automatic alps_pkg::out_t advance_chain(alps_pkg::in_t w);
    alps_pkg::out_t r;
    int             n;
    int             p1;
    logic [23:0]    c;
    r = '0;
    n = active_leds();
    c = {w.blue, w.green, w.red};
    case (w.action)
      alps_pkg::ACT_SET_LED: begin
        if (int'(w.led_index) < n) colour_mem[w.led_index] = c;
        else r.rejected = 1'b1;
      end
      alps_pkg::ACT_SET_ALL: begin
        for (int i = 0; i < n; i++) colour_mem[i] = c;
      end
      alps_pkg::ACT_CLEAR_ALL: begin
        for (int i = 0; i < n; i++) colour_mem[i] = '0;
      end
      alps_pkg::ACT_START: begin
        if (frame_on) begin
          r.rejected = 1'b1;
        end else begin
          frame_on = 1'b1;
          cur_led  = 0;
          cur_bit  = 0;
          tail_cnt = 0;
        end
      end
      alps_pkg::ACT_TICK: begin
        if (frame_on) begin
          r.slot_valid = 1'b1;
          if (cur_led < n) begin
            p1 = int'(cfg_period) + 1;
            r.compare_value = colour_mem[cur_led][COLOUR_BITS - 1 - cur_bit] ?
                              16'((p1 * 2) / 3) : 16'(p1 / 3);
            cur_bit++;
            if (cur_bit >= COLOUR_BITS) begin
              cur_bit = 0;
              cur_led++;
            end
          end else begin
            tail_cnt++;
            if (tail_cnt >= alps_pkg::RESET_SLOTS_DEF) begin
              r.last_slot = 1'b1;
              frame_on    = 1'b0;
              cur_led     = 0;
              cur_bit     = 0;
              tail_cnt    = 0;
            end
          end
        end
      end
      default: ;
    endcase
    r.busy_res = frame_on;
    return r;
  endfunction

  function automatic int draw_gap(bit on);
    return on ? int'($urandom_range(0, 19)) : 0;
  endfunction

  function automatic alps_pkg::in_t word(logic [2:0] act, logic [7:0] idx,
                                         logic [7:0] r, logic [7:0] g, logic [7:0] b);
    alps_pkg::in_t w;
    w.action    = act;
    w.led_index = idx;
    w.red       = r;
    w.green     = g;
    w.blue      = b;
    return w;
  endfunction

  function automatic alps_pkg::in_t rand_word(logic [2:0] act);
    return word(act, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic alps_pkg::in_t colour_word(int n);
    logic [7:0] idx;
    idx = 8'($urandom);
    if (n > 0 && $urandom_range(0, 7) != 0) idx = 8'($urandom_range(0, n - 1));
    return word(alps_pkg::ACT_SET_LED, idx, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic alps_pkg::in_t stray_word(int n);
    logic [2:0] act;
    act = 3'($urandom_range(0, 7));
    if (act == alps_pkg::ACT_SET_LED) return colour_word(n);
    return rand_word(act);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        slots_due.push_back(advance_chain(in_data));
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          in_data  <= pending.pop_front();
          in_valid <= 1'b1;
          send_gap = draw_gap(send_idle_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    alps_pkg::out_t exp_w;
    if (rst) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (slots_due.size() == 0) begin
          $display("%0t: output word with none expected, actual %h", $time, out_data);
          fail_count++;
        end else begin
          exp_w = slots_due.pop_front();
          check_field("compare_value", int'(exp_w.compare_value),
                      int'(out_data.compare_value));
          check_field("slot_valid", int'(exp_w.slot_valid), int'(out_data.slot_valid));
          check_field("last_slot", int'(exp_w.last_slot), int'(out_data.last_slot));
          check_field("busy_res", int'(exp_w.busy_res), int'(out_data.busy_res));
          check_field("rejected", int'(exp_w.rejected), int'(out_data.rejected));
          if (exp_w.last_slot) frames_done++;
          if (exp_w.rejected) rejects_seen++;
        end
        if (results_seen == 600 || results_seen == 1100) recv_hold = LONG_HOLD;
        else recv_hold = draw_gap(recv_idle_on);
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      out_stall <= (recv_hold > 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || slots_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == alps_pkg::REG_CHAIN_LEN) cfg_leds = val[8:0];
    else cfg_period = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] leds, input logic [15:0] period);
    int n;
    int added;
    int ticks;
    wait_drained();
    write_reg(alps_pkg::REG_CHAIN_LEN, leds);
    write_reg(alps_pkg::REG_PWM_PERIOD, period);
    settings++;
    @(negedge clk);
    send_idle_on = ($urandom_range(0, 2) != 0);
    recv_idle_on = ($urandom_range(0, 2) != 0);
    n = active_leds();
    added = 0;
    while (added < PHASE_WORDS) begin
      repeat ($urandom_range(0, 3)) begin
        pending.push_back(colour_word(n));
        added++;
      end
      pending.push_back(rand_word(alps_pkg::ACT_START));
      added++;
      ticks = n * COLOUR_BITS + alps_pkg::RESET_SLOTS_DEF + int'($urandom_range(0, 3));
      while (ticks > 0 && added < PHASE_WORDS) begin
        if ($urandom_range(0, 9) == 0) begin
          pending.push_back(stray_word(n));
        end else begin
          pending.push_back(rand_word(alps_pkg::ACT_TICK));
          ticks--;
        end
        added++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (in_stall !== 1'b0);

    write_reg(alps_pkg::REG_CHAIN_LEN, 16'd2);
    write_reg(alps_pkg::REG_PWM_PERIOD, 16'hFFFF);
    settings++;
    @(negedge clk);
    pending.push_back(word(alps_pkg::ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00));
    pending.push_back(word(alps_pkg::ACT_SET_LED, 8'd0, 8'hFF, 8'h00, 8'hA5));
    pending.push_back(word(alps_pkg::ACT_SET_LED, 8'd1, 8'h00, 8'hFF, 8'h5A));
    pending.push_back(word(alps_pkg::ACT_SET_LED, 8'd2, 8'hFF, 8'hFF, 8'hFF));
    pending.push_back(word(alps_pkg::ACT_SET_LED, 8'd255, 8'hAA, 8'h55, 8'hFF));
    pending.push_back(word(ACT_SPARE_FIRST, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    pending.push_back(word(ACT_SPARE_FIRST + 3'd1, 8'h00, 8'h00, 8'h00, 8'h00));
    pending.push_back(word(ACT_SPARE_LAST, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    pending.push_back(word(alps_pkg::ACT_SET_ALL, 8'd0, 8'h12, 8'h34, 8'h56));
    pending.push_back(word(alps_pkg::ACT_CLEAR_ALL, 8'd0, 8'h00, 8'h00, 8'h00));
    pending.push_back(word(alps_pkg::ACT_SET_LED, 8'd0, 8'hFF, 8'h00, 8'hA5));
    pending.push_back(word(alps_pkg::ACT_SET_LED, 8'd1, 8'h00, 8'hFF, 8'h5A));
    pending.push_back(word(alps_pkg::ACT_START, 8'd0, 8'h00, 8'h00, 8'h00));
    pending.push_back(word(alps_pkg::ACT_START, 8'd0, 8'h00, 8'h00, 8'h00));
    repeat (6) pending.push_back(word(alps_pkg::ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00));
    pending.push_back(word(alps_pkg::ACT_SET_LED, 8'd1, 8'hFF, 8'hFF, 8'hFF));
    repeat (2) pending.push_back(word(alps_pkg::ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00));

    run_phase(16'd0, 16'd0);
    run_phase(16'd1, 16'hFFFF);
    run_phase(16'd2, alps_pkg::PERIOD_RESET);
    run_phase(16'd256, 16'd1);
    run_phase(16'd511, 16'($urandom));
    run_phase(16'd3, 16'($urandom));
    run_phase(16'd1, 16'd2);
    run_phase(16'd4, 16'($urandom));

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("covered %0d words over %0d register settings", words_in, settings);
    $display("%0d frames closed, %0d words rejected", frames_done, rejects_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/alps_pkg.sv
hw/rtl/alps_ram.sv
hw/rtl/alps_ctrl.sv
hw/rtl/alps_dp.sv
hw/rtl/addressable_led_pwm_serializer.sv
verif/tb_addressable_led_pwm_serializer.sv
